// ===== rtl/core/smconv_pkg.sv =====
// ---------------------------------------------------------------------------
// smconv_pkg: shared definitions for the 3x3 smoothing filter
// Widths, register indexes, the line store entry layout and pipeline flags.
// ---------------------------------------------------------------------------
package smconv_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 16;
    localparam int ROW_W      = 17;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int ENTRY_W    = 2 * PIX_W;
    localparam int SUM_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // floor(x / 9) == (x * RECIP_NINE) >> RECIP_SHIFT for every x below 2^15
    localparam int RECIP_SHIFT = 15;
    localparam logic [SUM_W-1:0] RECIP_NINE = 12'd3641;
    localparam logic [CH_W-1:0]  PIX_MAX    = 8'd255;

    localparam logic [ROW_W-1:0] ROW_LIMIT = 17'h1FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_MODE  = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2,
        CFG_COLOR_MODE   = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_FLUSH = 1'b1
    } req_type_t;

    // Line store write: the entry holds {row two above, row one above}.
    typedef struct packed {
        logic                 en;
        logic [COL_W-1:0]     addr;
        logic [ENTRY_W-1:0]   data;
    } line_wr_t;

    // What a window position needs to know about the centre pixel it serves.
    typedef struct packed {
        logic has_res;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;
        logic weighted;
        logic color;
    } res_flags_t;

endpackage

// ===== rtl/core/smconv_in_if.sv =====
// ---------------------------------------------------------------------------
// smconv_in_if: request channel of the smoothing filter
// Valid/ready channel carrying one pixel or flush request.
// ---------------------------------------------------------------------------
interface smconv_in_if import smconv_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            req_type;
    logic [CH_W-1:0] in_ch0;
    logic [CH_W-1:0] in_ch1;
    logic [CH_W-1:0] in_ch2;

    modport source (output valid, output req_type, output in_ch0, output in_ch1,
                    output in_ch2, input ready);
    modport sink   (input valid, input req_type, input in_ch0, input in_ch1,
                    input in_ch2, output ready);
endinterface

// ===== rtl/core/smconv_out_if.sv =====
// ---------------------------------------------------------------------------
// smconv_out_if: result channel of the smoothing filter
// Valid/ready channel carrying one smoothed pixel.
// ---------------------------------------------------------------------------
interface smconv_out_if import smconv_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_ch0;
    logic [CH_W-1:0] out_ch1;
    logic [CH_W-1:0] out_ch2;
    logic            frame_last;

    modport source (output valid, output out_ch0, output out_ch1, output out_ch2,
                    output frame_last, input ready);
    modport sink   (input valid, input out_ch0, input out_ch1, input out_ch2,
                    input frame_last, output ready);
endinterface

// ===== rtl/core/smconv_line_mem.sv =====
// ---------------------------------------------------------------------------
// smconv_line_mem: two-row line store
// Single memory of MAX_WIDTH entries with registered read data and a bypass
// for a read of the entry that is being written on the same edge.
// ---------------------------------------------------------------------------
module smconv_line_mem import smconv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  logic [COL_W-1:0]   rd_addr,
    input  line_wr_t           wr,
    output logic [ENTRY_W-1:0] rd_data
);

    logic [ENTRY_W-1:0] mem [0:MAX_WIDTH-1];
    logic [ENTRY_W-1:0] mem_q_reg;
    logic [ENTRY_W-1:0] byp_data_reg;
    logic               byp_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // The memory returns the old entry when read and write meet, so the
    // written value is kept aside and chosen instead.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_reg <= wr.en && (wr.addr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            byp_data_reg <= wr.data;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : mem_q_reg;

endmodule

// ===== rtl/core/smoothing_conv3x3_top.sv =====
// ---------------------------------------------------------------------------
// smoothing_conv3x3_top: 3x3 mean / weighted smoothing filter
// Raster pixel stream in, smoothed pixel stream out, a two-row line store and a
// 3x3 window; one request per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
// Path: a result leaves through the stage 1, window, sum and output registers
// after the request that completes its window (W+1 requests after its own pixel).
// Throughput: one request per cycle; the four-stage pipeline (line store read,
// window, sum, divide) stalls only when every stage is full and out_res.ready is low.
// Reset: asynchronous, active low; resets the config, clears frame position, window
// and valid bits. The line store is not cleared; unwritten entries feed edges only.
module smoothing_conv3x3_top import smconv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    smconv_in_if.sink             in_req,
    smconv_out_if.source          out_res
);

    // ---------------- configuration ----------------
    logic                kernel_mode_reg;
    logic [WIDTH_W-1:0]  image_width_reg;
    logic [HEIGHT_W-1:0] image_height_reg;
    logic                color_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_mode_reg  <= 1'b0;
            image_width_reg  <= WIDTH_W'(MAX_WIDTH);
            image_height_reg <= HEIGHT_W'(1024);
            color_mode_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_KERNEL_MODE:  kernel_mode_reg  <= cfg_wdata[0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[HEIGHT_W-1:0];
                CFG_COLOR_MODE:   color_mode_reg   <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    logic [WIDTH_W-1:0]  eff_w;
    logic [HEIGHT_W-1:0] eff_h;

    always_comb
    begin
        if (image_width_reg == '0)
            eff_w = WIDTH_W'(1);
        else if (image_width_reg > WIDTH_W'(MAX_WIDTH))
            eff_w = WIDTH_W'(MAX_WIDTH);
        else
            eff_w = image_width_reg;
        eff_h = (image_height_reg == '0) ? HEIGHT_W'(1) : image_height_reg;
    end

    // ---------------- pipeline control ----------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;
    logic out_adv;
    logic s3_adv;
    logic s2_adv;
    logic s1_adv;
    logic req_acc;
    logic s1_load;

    assign out_adv = !out_valid_reg || out_res.ready;
    assign s3_adv  = !s3_valid_reg || out_adv;
    assign s2_adv  = !s2_valid_reg || s3_adv;
    assign s1_adv  = !s1_valid_reg || s2_adv;

    assign in_req.ready = s1_adv;
    assign req_acc      = in_req.valid && s1_adv;

    // ---------------- frame position ----------------
    logic [ROW_W-1:0]   in_row_reg;
    logic [COL_W-1:0]   in_col_reg;
    logic [ROW_W-1:0]   in_row_next;
    logic [COL_W-1:0]   in_col_next;
    logic               in_frame;
    logic               is_pixel;
    logic               col_nz;
    logic [ROW_W:0]     cr_ext;
    logic [ROW_W-1:0]   cr;
    logic [WIDTH_W-1:0] cc;
    logic [ROW_W-1:0]   h_ext;
    res_flags_t         nx_flags;
    logic [PIX_W-1:0]   nx_fresh;

    always_comb
    begin
        h_ext    = {1'b0, eff_h};
        in_frame = in_row_reg < h_ext;
        is_pixel = (req_type_t'(in_req.req_type) == REQ_PIXEL) && in_frame;
        // A flush that arrives inside the frame is dropped without effect.
        s1_load  = req_acc && (is_pixel || !in_frame);
        col_nz   = in_col_reg != '0;

        // The centre pixel sits W+1 positions behind the arriving one.
        cr_ext = {1'b0, in_row_reg} - (col_nz ? (ROW_W+1)'(1) : (ROW_W+1)'(2));
        cr     = cr_ext[ROW_W-1:0];
        cc     = col_nz ? ({1'b0, in_col_reg} - WIDTH_W'(1)) : (eff_w - WIDTH_W'(1));

        nx_flags.has_res  = !cr_ext[ROW_W] && (cr < h_ext) && (cc < eff_w);
        nx_flags.top_ok   = cr != '0;
        nx_flags.bot_ok   = cr < (h_ext - ROW_W'(1));
        nx_flags.left_ok  = cc != '0;
        nx_flags.right_ok = cc != (eff_w - WIDTH_W'(1));
        nx_flags.last     = (cr == (h_ext - ROW_W'(1))) && (cc == (eff_w - WIDTH_W'(1)));
        nx_flags.weighted = kernel_mode_reg;
        nx_flags.color    = color_mode_reg;

        nx_fresh = '0;
        if (is_pixel)
        begin
            nx_fresh[CH_W-1:0] = in_req.in_ch0;
            if (color_mode_reg)
            begin
                nx_fresh[2*CH_W-1:CH_W] = in_req.in_ch1;
                nx_fresh[PIX_W-1:2*CH_W] = in_req.in_ch2;
            end
        end

        in_row_next = in_row_reg;
        in_col_next = in_col_reg;
        if (({1'b0, in_col_reg} + WIDTH_W'(1)) >= eff_w)
        begin
            in_col_next = '0;
            if (in_row_reg < ROW_LIMIT)
                in_row_next = in_row_reg + ROW_W'(1);
        end
        else
        begin
            in_col_next = in_col_reg + COL_W'(1);
        end
        if (nx_flags.has_res && nx_flags.last)
        begin
            in_row_next = '0;
            in_col_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg <= '0;
            in_col_reg <= '0;
        end
        else if (s1_load)
        begin
            in_row_reg <= in_row_next;
            in_col_reg <= in_col_next;
        end
    end

    // ---------------- stage 1: line store read ----------------
    logic [PIX_W-1:0]   s1_fresh_reg;
    logic [COL_W-1:0]   s1_col_reg;
    res_flags_t         s1_flags_reg;
    logic [ENTRY_W-1:0] line_rd_data;
    line_wr_t           line_wr;
    logic               s1_move;

    assign s1_move = s1_valid_reg && s2_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_adv)
            s1_valid_reg <= s1_load;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_fresh_reg <= nx_fresh;
            s1_col_reg   <= in_col_reg;
            s1_flags_reg <= nx_flags;
        end
    end

    // The row one above moves up, the fresh pixel becomes the row one above.
    assign line_wr.en   = s1_move;
    assign line_wr.addr = s1_col_reg;
    assign line_wr.data = {line_rd_data[PIX_W-1:0], s1_fresh_reg};

    smconv_line_mem u_line_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (s1_load),
        .rd_addr (in_col_reg),
        .wr      (line_wr),
        .rd_data (line_rd_data)
    );

    // ---------------- stage 2: window ----------------
    logic [PIX_W-1:0] win_reg [0:8];
    res_flags_t       s2_flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            if (s2_adv)
                s2_valid_reg <= s1_move && s1_flags_reg.has_res;
            if (s1_move)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3]   <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[2] <= line_rd_data[ENTRY_W-1:PIX_W];
                win_reg[5] <= line_rd_data[PIX_W-1:0];
                win_reg[8] <= s1_fresh_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
            s2_flags_reg <= s1_flags_reg;
    end

    // ---------------- stage 3: weighted sums ----------------
    logic [SUM_W-1:0] sum_comb [0:2];
    logic [SUM_W-1:0] s3_sum_reg [0:2];
    logic             s3_weighted_reg;
    logic             s3_color_reg;
    logic             s3_last_reg;
    logic             s3_move;

    assign s3_move = s2_valid_reg && s3_adv;

    // Neighbours outside the image take the centre value; the weighted kernel
    // doubles once per axis on which the slot is central.
    always_comb
    begin
        logic            row_ok;
        logic            col_ok;
        logic [1:0]      shamt;
        logic [CH_W-1:0] ctr;
        logic [CH_W-1:0] px;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum_comb[ch] = '0;
            ctr = win_reg[4][ch*CH_W +: CH_W];
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    row_ok = (r == 0) ? s2_flags_reg.top_ok :
                             (r == 2) ? s2_flags_reg.bot_ok : 1'b1;
                    col_ok = (c == 0) ? s2_flags_reg.left_ok :
                             (c == 2) ? s2_flags_reg.right_ok : 1'b1;
                    px = (row_ok && col_ok) ? win_reg[r*3+c][ch*CH_W +: CH_W] : ctr;
                    shamt = s2_flags_reg.weighted ?
                            (2'((r == 1) ? 1 : 0) + 2'((c == 1) ? 1 : 0)) : 2'd0;
                    sum_comb[ch] = sum_comb[ch] + (SUM_W'(px) << shamt);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (s3_adv)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_move)
        begin
            for (int ch = 0; ch < 3; ch++)
                s3_sum_reg[ch] <= sum_comb[ch];
            s3_weighted_reg <= s2_flags_reg.weighted;
            s3_color_reg    <= s2_flags_reg.color;
            s3_last_reg     <= s2_flags_reg.last;
        end
    end

    // ---------------- stage 4: divide, clamp, output register ----------------
    logic [CH_W-1:0] quot_comb [0:2];
    logic            out_move;

    assign out_move = s3_valid_reg && out_adv;

    always_comb
    begin
        logic [2*SUM_W-1:0] prod;
        logic [CH_W:0]      q;
        for (int ch = 0; ch < 3; ch++)
        begin
            prod = {{SUM_W{1'b0}}, s3_sum_reg[ch]} * {{SUM_W{1'b0}}, RECIP_NINE};
            if (s3_weighted_reg)
                q = (CH_W+1)'(s3_sum_reg[ch] >> 4);
            else
                q = prod[RECIP_SHIFT +: CH_W+1];
            quot_comb[ch] = (q > {1'b0, PIX_MAX}) ? PIX_MAX : q[CH_W-1:0];
        end
    end

    logic [CH_W-1:0] out_ch0_reg;
    logic [CH_W-1:0] out_ch1_reg;
    logic [CH_W-1:0] out_ch2_reg;
    logic            frame_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_adv)
            out_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_move)
        begin
            out_ch0_reg    <= quot_comb[0];
            out_ch1_reg    <= s3_color_reg ? quot_comb[1] : '0;
            out_ch2_reg    <= s3_color_reg ? quot_comb[2] : '0;
            frame_last_reg <= s3_last_reg;
        end
    end

    assign out_res.valid      = out_valid_reg;
    assign out_res.out_ch0    = out_ch0_reg;
    assign out_res.out_ch1    = out_ch1_reg;
    assign out_res.out_ch2    = out_ch2_reg;
    assign out_res.frame_last = frame_last_reg;

`ifndef ASSERT_OFF
    // The last result of a frame sends the arrival position back to the origin.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_load && nx_flags.has_res && nx_flags.last |=> (in_row_reg == '0) && (in_col_reg == '0))
        else $error("frame position not cleared after the last result");

    // A stalled stage 1 must keep its line store data for the window update.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_adv |=> $stable(line_rd_data))
        else $error("line store data changed under a stalled stage");

    // The window must not move while a result still needs it.
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s3_adv |=> $stable(win_reg[4]) && $stable(win_reg[0]))
        else $error("window shifted under a waiting result");

    // Only items that carry a result reach the sum stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && !s1_flags_reg.has_res |=> !s2_valid_reg)
        else $error("result raised for a window position outside the image");
`endif

endmodule
